@@ design/sdd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants of the stream duplicate detector: word
// layouts, table geometry, hash constant, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;
    localparam int EPOCH_W  = 8;

    localparam logic [VALUE_W-1:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic has_duplicate;
        logic overflow;
    } t_out_word;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic insert;
        logic mark_dup;
        logic mark_full;
        logic advance;
        logic finish;
        logic clr_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic match;
        logic probe_last;
        logic clr_last;
        logic epoch_last;
        logic last;
    } t_dp_stat;

endpackage

@@ design/stream_duplicate_detector.sv @@
// Result: the strobe is registered from the compare that resolves the last word of an array.
// Words: a new word is accepted only while busy is low, once the previous one is resolved; each linear
// probe is one table RAM read followed by one compare, at most 1024 probes per word.
// Reset: synchronous; busy stays high for a table sweep that clears all 1024 entries after reset and
// again after every 255th array, when the entry epoch tag wraps.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// stream_duplicate_detector
// Flags repeated values within an array of words using an open-addressed
// hash set with linear probing; one result per array.
// ----------------------------------------------------------------------------
module stream_duplicate_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sdd_pkg::t_in_word  i_word,
    output logic               o_valid,
    output sdd_pkg::t_out_word o_result
);
    import sdd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_state   w_state;

    sdd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_state (w_state)
    );

    sdd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && w_state == S_READ))
        else $error("accepted word did not start a probe");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.insert, w_cmd.mark_dup, w_cmd.mark_full, w_cmd.advance}))
        else $error("more than one probe outcome");

    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_state == S_CHECK && w_stat.last))
        else $error("result without a finished last word");
`endif

endmodule

@@ design/sdd_ram.sv @@
// ----------------------------------------------------------------------------
// sdd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sdd_datapath.sv @@
// ----------------------------------------------------------------------------
// sdd_datapath
// Hash table datapath: home slot hash, linear probe address, entry
// compare, epoch-tagged table RAM, sticky flags and result register.
// ----------------------------------------------------------------------------
module sdd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdd_pkg::t_in_word i_word,
    input  sdd_pkg::t_dp_cmd  i_cmd,
    output sdd_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output sdd_pkg::t_out_word o_result
);
    import sdd_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic               r_last;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_probes;
    logic [SLOT_W-1:0]  r_clr_addr;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_dup;
    logic               r_full;
    logic               r_valid;
    t_out_word          r_result;

    logic [VALUE_W-1:0] w_prod;
    logic [15:0]        w_hash;
    logic [SLOT_W-1:0]  w_home;
    logic [SLOT_W-1:0]  w_slot_inc;
    logic               n_dup;
    logic               n_full;
    logic               w_occupied;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    t_entry             w_wentry;
    t_entry             w_rentry;
    logic [$bits(t_entry)-1:0] w_rdata;

    assign w_prod = $unsigned(i_word.value) * HASH_MULT;
    assign w_hash = w_prod[31:16];
    assign w_home = SLOT_W'(w_hash % CAPACITY);

    assign w_slot_inc = (r_slot == SLOT_W'(CAPACITY - 1)) ? '0 : r_slot + 1'b1;

    assign n_dup  = r_dup  | i_cmd.mark_dup;
    assign n_full = r_full | i_cmd.mark_full;

    // table RAM, tagged with the epoch of the array that wrote the entry
    assign w_we         = i_cmd.insert | i_cmd.clr_wr;
    assign w_waddr      = i_cmd.clr_wr ? r_clr_addr : r_slot;
    assign w_wentry     = i_cmd.clr_wr ? t_entry'('0) : t_entry'({r_epoch, r_value});
    assign w_rentry     = t_entry'(w_rdata);

    sdd_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (i_cmd.rd),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    assign w_occupied = (w_rentry.epoch == r_epoch);

    assign o_stat.empty      = !w_occupied;
    assign o_stat.match      = w_occupied && (w_rentry.value == r_value);
    assign o_stat.probe_last = (r_probes == SLOT_W'(CAPACITY - 1));
    assign o_stat.clr_last   = (r_clr_addr == SLOT_W'(CAPACITY - 1));
    assign o_stat.epoch_last = &r_epoch;
    assign o_stat.last       = r_last;

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= $unsigned(i_word.value);
            r_last  <= i_word.last;
            r_slot  <= w_home;
            r_probes <= '0;
        end else if (i_cmd.advance) begin
            r_slot   <= w_slot_inc;
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.finish && r_last) begin
            r_result.has_duplicate <= n_dup;
            r_result.overflow      <= n_full;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_W'(1);
            r_dup      <= 1'b0;
            r_full     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish && r_last;
            if (i_cmd.clr_wr) begin
                r_clr_addr <= o_stat.clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.finish && r_last) begin
                r_dup   <= 1'b0;
                r_full  <= 1'b0;
                r_epoch <= o_stat.epoch_last ? EPOCH_W'(1) : r_epoch + 1'b1;
            end else begin
                r_dup  <= n_dup;
                r_full <= n_full;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/sdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdd_ctrl
// Controller: table clearing sweep, word accept, and the read/compare
// probe loop over the table.
// ----------------------------------------------------------------------------
module sdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sdd_pkg::t_dp_stat i_stat,
    output sdd_pkg::t_dp_cmd  o_cmd,
    output sdd_pkg::t_state   o_state
);
    import sdd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_done;

    assign w_done = i_stat.empty || i_stat.match || i_stat.probe_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_done) begin
                    n_state = (i_stat.last && i_stat.epoch_last) ? S_CLEAR : S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_CHECK: begin
                o_cmd.finish = w_done;
                if (i_stat.empty) begin
                    o_cmd.insert = 1'b1;
                end else if (i_stat.match) begin
                    o_cmd.mark_dup = 1'b1;
                end else if (i_stat.probe_last) begin
                    o_cmd.mark_full = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_state = r_state;

endmodule
